### sv/icig_pkg.sv
// Package with shared constants, request codes and item types for the input-gradient block.
package icig_pkg;

  localparam int MAX_ROWS_DEF     = 32;
  localparam int MAX_COLS_DEF     = 32;
  localparam int MAX_CHANNELS_DEF = 16;
  localparam int MAX_TAPS_DEF     = 5;
  localparam int MAX_SETS_DEF     = 8;

  localparam int VALUE_W = 16;
  localparam int SUM_W   = 41;
  localparam int CFG_W   = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] REQ_COEF   = 2'd0;
  localparam logic [1:0] REQ_GRAD   = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [2:0] CFG_IN_ROWS      = 3'd0;
  localparam logic [2:0] CFG_IN_COLS      = 3'd1;
  localparam logic [2:0] CFG_IN_CHANNELS  = 3'd2;
  localparam logic [2:0] CFG_OUT_ROWS     = 3'd3;
  localparam logic [2:0] CFG_OUT_COLS     = 3'd4;
  localparam logic [2:0] CFG_OUT_CHANNELS = 3'd5;
  localparam logic [2:0] CFG_TAP_ROWS     = 3'd6;
  localparam logic [2:0] CFG_TAP_COLS     = 3'd7;

  // One request item.
  typedef struct packed {
    logic [1:0]         req_type;
    logic [4:0]         row;
    logic [4:0]         col;
    logic [3:0]         out_chan;
    logic [3:0]         in_chan;
    logic [2:0]         tap_row;
    logic [2:0]         tap_col;
    logic [2:0]         set_index;
    logic signed [15:0] value;
  } req_item_t;

  // One result item.
  typedef struct packed {
    logic signed [40:0] grad_sum;
    logic               bad_position;
  } grad_result_t;

endpackage

### sv/icig_if.sv
// Valid/ready channel interface used for request and result items.
interface icig_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/icig_mem.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
module icig_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/indexed_conv_input_gradient.sv
// A query walks every tap; for each in-range tap it issues one grid read per output channel,
// and it passes over each tap out of range without a read. A query at a bad position goes
// straight to the output state. The next item is taken only once the block is back in idle;
// writes are taken in idle and give no result. A product is accumulated once its grid
// address has passed the s1, s2 and s3 pipeline registers. A result waits in an output
// register. Reset (synchronous, active high) restores the size registers, state and valids.
module indexed_conv_input_gradient #(
  parameter int MAX_ROWS     = icig_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS     = icig_pkg::MAX_COLS_DEF,
  parameter int MAX_CHANNELS = icig_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_TAPS     = icig_pkg::MAX_TAPS_DEF,
  parameter int MAX_SETS     = icig_pkg::MAX_SETS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_we,
  input logic [icig_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [icig_pkg::CFG_W-1:0]    cfg_data,
  icig_if.sink                         req,
  icig_if.source                       rsp
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int HW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int TW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int GDEPTH = MAX_ROWS * MAX_COLS * MAX_CHANNELS;
  localparam int CDEPTH = MAX_SETS * MAX_TAPS * MAX_TAPS * MAX_CHANNELS * MAX_CHANNELS;
  localparam int GA = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
  localparam int CA = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int VW = icig_pkg::VALUE_W;
  localparam int SUMW = icig_pkg::SUM_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RUN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;

  // Size registers.
  logic [5:0] in_rows, in_cols, grid_rows, grid_cols;
  logic [4:0] in_channels, out_channels;
  logic [2:0] tap_rows, tap_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_rows <= 6'd32; in_cols <= 6'd32; in_channels <= 5'd16;
      grid_rows <= 6'd32; grid_cols <= 6'd32; out_channels <= 5'd16;
      tap_rows <= 3'd3; tap_cols <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        icig_pkg::CFG_IN_ROWS:      in_rows <= cfg_data;
        icig_pkg::CFG_IN_COLS:      in_cols <= cfg_data;
        icig_pkg::CFG_IN_CHANNELS:  in_channels <= cfg_data[4:0];
        icig_pkg::CFG_OUT_ROWS:     grid_rows <= cfg_data;
        icig_pkg::CFG_OUT_COLS:     grid_cols <= cfg_data;
        icig_pkg::CFG_OUT_CHANNELS: out_channels <= cfg_data[4:0];
        icig_pkg::CFG_TAP_ROWS:     tap_rows <= cfg_data[2:0];
        icig_pkg::CFG_TAP_COLS:     tap_cols <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Saturated sizes, signed 13-bit working values.
  function automatic logic signed [12:0] sat(input logic [5:0] v, input int lim);
    logic signed [12:0] r;
    r = (32'(v) > lim) ? 13'(lim) : 13'(v);
    return r;
  endfunction

  logic signed [12:0] s_ir, s_ic, s_ich, s_or, s_oc, s_och, s_kr, s_kc;
  assign s_ir  = sat(in_rows, MAX_ROWS);
  assign s_ic  = sat(in_cols, MAX_COLS);
  assign s_ich = sat({1'b0, in_channels}, MAX_CHANNELS);
  assign s_or  = sat(grid_rows, MAX_ROWS);
  assign s_oc  = sat(grid_cols, MAX_COLS);
  assign s_och = sat({1'b0, out_channels}, MAX_CHANNELS);
  assign s_kr  = sat({3'b0, tap_rows}, MAX_TAPS);
  assign s_kc  = sat({3'b0, tap_cols}, MAX_TAPS);

  logic signed [12:0] dr, dc, offr, offc;
  assign dr = s_ir - 13'sd1 + s_kr - s_or;
  assign dc = s_ic - 13'sd1 + s_kc - s_oc;
  assign offr = (dr > 0) ? (dr >>> 1) : 13'sd0;
  assign offc = (dc > 0) ? (dc >>> 1) : 13'sd0;

  // Request decode.
  logic [1:0] r_type;
  logic [4:0] r_row, r_col;
  logic [3:0] r_oc, r_ic;
  logic [2:0] r_tr, r_tc, r_set;
  logic [VW-1:0] r_val;
  assign r_type = req.data.req_type;
  assign r_row = req.data.row;
  assign r_col = req.data.col;
  assign r_oc = req.data.out_chan;
  assign r_ic = req.data.in_chan;
  assign r_tr = req.data.tap_row;
  assign r_tc = req.data.tap_col;
  assign r_set = req.data.set_index;
  assign r_val = req.data.value;

  logic [2:0] state;
  logic accept;
  assign req.ready = (state == ST_IDLE);
  assign accept = req.valid && req.ready;

  // Write address computation.
  logic gw_ok, cw_ok;
  logic [GA-1:0] gw_addr;
  logic [CA-1:0] cw_addr;
  assign gw_ok = accept && (r_type == icig_pkg::REQ_GRAD) && (32'(r_row) < MAX_ROWS)
                 && (32'(r_col) < MAX_COLS) && (32'(r_oc) < MAX_CHANNELS)
                 && (32'(r_set) < MAX_SETS);
  assign cw_ok = accept && (r_type == icig_pkg::REQ_COEF) && (32'(r_tr) < MAX_TAPS)
                 && (32'(r_tc) < MAX_TAPS) && (32'(r_ic) < MAX_CHANNELS)
                 && (32'(r_oc) < MAX_CHANNELS) && (32'(r_set) < MAX_SETS);
  assign gw_addr = GA'((32'(r_row) * MAX_COLS + 32'(r_col)) * MAX_CHANNELS + 32'(r_oc));
  assign cw_addr = CA'((((32'(r_set) * MAX_TAPS + 32'(r_tr)) * MAX_TAPS + 32'(r_tc))
                       * MAX_CHANNELS + 32'(r_ic)) * MAX_CHANNELS + 32'(r_oc));

  // Query sequencer registers.
  logic [4:0] q_row, q_col;
  logic [3:0] q_ic;
  logic [TW:0] fr, fc;
  logic [HW:0] och;
  logic signed [12:0] gr, gc;
  logic tap_ok, step_last_o, step_last_fc, step_last_fr, issue;

  assign gr = 13'(q_row) + 13'(fr) - offr;
  assign gc = 13'(q_col) + 13'(fc) - offc;
  assign tap_ok = (gr >= 0) && (gr < s_or) && (gc >= 0) && (gc < s_oc);
  assign step_last_o = !tap_ok || (13'(och) + 13'sd1 >= s_och) || (s_och == 0);
  assign step_last_fc = 13'(fc) + 13'sd1 >= s_kc;
  assign step_last_fr = 13'(fr) + 13'sd1 >= s_kr;
  assign issue = (state == ST_RUN) && tap_ok && (13'(och) < s_och);

  logic [GA-1:0] gr_addr;
  assign gr_addr = GA'((32'(gr[RW:0] & {(RW+1){1'b1}}) * MAX_COLS
                       + 32'(gc[CW:0])) * MAX_CHANNELS + 32'(och));

  // Stage 1 pipeline: tap and channel for the coefficient address.
  logic s1_v, s2_v, s3_v;
  logic [TW:0] s1_tr, s1_tc;
  logic [HW:0] s1_o;
  logic [VW-1:0] g_q, s2_g, c_q;
  logic [2:0] sel_q;
  logic [CA-1:0] cr_addr;
  logic s2_ok;

  assign cr_addr = CA'((((32'(sel_q) * MAX_TAPS + 32'(s1_tr)) * MAX_TAPS + 32'(s1_tc))
                       * MAX_CHANNELS + 32'(q_ic)) * MAX_CHANNELS + 32'(s1_o));

  icig_mem #(.DEPTH(GDEPTH), .WIDTH(VW)) u_grad (
    .clk(clk), .we(gw_ok), .waddr(gw_addr), .wdata(r_val),
    .raddr(gr_addr), .rdata(g_q));
  icig_mem #(.DEPTH(GDEPTH), .WIDTH(3)) u_sel (
    .clk(clk), .we(gw_ok), .waddr(gw_addr), .wdata(r_set),
    .raddr(gr_addr), .rdata(sel_q));
  icig_mem #(.DEPTH(CDEPTH), .WIDTH(VW)) u_coef (
    .clk(clk), .we(cw_ok), .waddr(cw_addr), .wdata(r_val),
    .raddr(cr_addr), .rdata(c_q));

  logic signed [31:0] prod;
  logic s3_ok;
  logic signed [SUMW-1:0] acc;
  logic [SUMW-1:0] out_sum;
  logic q_bad, out_bad, out_valid;
  logic [1:0] drain;

  // Pipeline from address issue to accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
    s1_tr <= (TW+1)'(s_kr - 13'sd1 - 13'(fr));
    s1_tc <= (TW+1)'(s_kc - 13'sd1 - 13'(fc));
    s1_o <= och;
    s2_g <= g_q;
    s2_ok <= (32'(sel_q) < MAX_SETS);
    prod <= $signed(s2_g) * $signed(c_q);
    s3_ok <= s2_ok;
  end

  // Sequencer and accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && r_type == icig_pkg::REQ_QUERY) begin
            q_row <= r_row; q_col <= r_col; q_ic <= r_ic;
            fr <= '0; fc <= '0; och <= '0;
            acc <= '0;
            if (13'(r_row) >= s_ir || 13'(r_col) >= s_ic || 13'(r_ic) >= s_ich) begin
              q_bad <= 1'b1;
              state <= ST_OUT;
            end else begin
              q_bad <= 1'b0;
              state <= (s_kr == 0 || s_kc == 0) ? ST_DRAIN : ST_RUN;
            end
            drain <= '0;
          end
        end
        ST_RUN: begin
          if (step_last_o) begin
            och <= '0;
            if (step_last_fc) begin
              fc <= '0;
              if (step_last_fr) state <= ST_DRAIN;
              else fr <= fr + 1'b1;
            end else begin
              fc <= fc + 1'b1;
            end
          end else begin
            och <= och + 1'b1;
          end
        end
        ST_DRAIN: begin
          drain <= drain + 1'b1;
          if (drain == 2'd3) state <= ST_OUT;
        end
        ST_OUT: begin
          // The result register is loaded only once the previous item has left.
          if (!out_valid) begin
            out_sum <= q_bad ? '0 : acc;
            out_bad <= q_bad;
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (s3_v && s3_ok) acc <= acc + SUMW'(prod);
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data.grad_sum = out_sum;
  assign rsp.data.bad_position = out_bad;

endmodule

### sim/indexed_conv_input_gradient_tb.sv
// Self-checking testbench for the indexed convolution input-gradient block.
`timescale 1ns / 100ps

module indexed_conv_input_gradient_tb;

  localparam int GRID_DEPTH = 32 * 32 * 16;
  localparam int COEF_DEPTH = 8 * 5 * 5 * 16 * 16;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int DRAIN_CYCLES = 450;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [icig_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [icig_pkg::CFG_W-1:0] cfg_data = '0;

  icig_if #(.payload_t(icig_pkg::req_item_t)) req_ch ();
  icig_if #(.payload_t(icig_pkg::grad_result_t)) rsp_ch ();

  indexed_conv_input_gradient dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_ch), .rsp(rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the block's sizes and memories.
  int size_reg [8];
  logic signed [15:0] grad_mem [GRID_DEPTH];
  logic [2:0]         sel_mem [GRID_DEPTH];
  bit                 grad_written [GRID_DEPTH];
  logic signed [15:0] coef_mem [COEF_DEPTH];
  bit                 coef_written [COEF_DEPTH];

  icig_pkg::req_item_t    pending_items [$];
  icig_pkg::grad_result_t expected_sums [$];
  int errors = 0;
  longint cycle_count = 0;

  function automatic int eff_size(int idx);
    int lim [8] = '{32, 32, 16, 32, 32, 16, 5, 5};
    return (size_reg[idx] > lim[idx]) ? lim[idx] : size_reg[idx];
  endfunction

  function automatic int grid_index(int r, int c, int o);
    return (r * 32 + c) * 16 + o;
  endfunction

  function automatic int coef_index(int s, int tr, int tc, int i, int o);
    return (((s * 5 + tr) * 5 + tc) * 16 + i) * 16 + o;
  endfunction

  // Input gradient at one position from the shadow memories.
  function automatic icig_pkg::grad_result_t input_gradient(int row, int col, int ic);
    icig_pkg::grad_result_t res;
    longint acc = 0;
    int ir, icl, ich, orw, ocl, och, kr, kc, offr, offc, gr, gc, ga, s;
    ir = eff_size(icig_pkg::CFG_IN_ROWS); icl = eff_size(icig_pkg::CFG_IN_COLS);
    ich = eff_size(icig_pkg::CFG_IN_CHANNELS);
    orw = eff_size(icig_pkg::CFG_OUT_ROWS); ocl = eff_size(icig_pkg::CFG_OUT_COLS);
    och = eff_size(icig_pkg::CFG_OUT_CHANNELS);
    kr = eff_size(icig_pkg::CFG_TAP_ROWS); kc = eff_size(icig_pkg::CFG_TAP_COLS);
    if (row >= ir || col >= icl || ic >= ich) begin
      res.grad_sum = '0;
      res.bad_position = 1'b1;
      return res;
    end
    offr = ir - 1 + kr - orw;
    offc = icl - 1 + kc - ocl;
    offr = (offr > 0) ? offr / 2 : 0;
    offc = (offc > 0) ? offc / 2 : 0;
    for (int fr = 0; fr < kr; fr++) begin
      gr = row + fr - offr;
      if (gr < 0 || gr >= orw) continue;
      for (int fc = 0; fc < kc; fc++) begin
        gc = col + fc - offc;
        if (gc < 0 || gc >= ocl) continue;
        for (int o = 0; o < och; o++) begin
          ga = grid_index(gr, gc, o);
          s = sel_mem[ga];
          acc += longint'(grad_mem[ga]) *
                 longint'(coef_mem[coef_index(s, kr - 1 - fr, kc - 1 - fc, ic, o)]);
        end
      end
    end
    res.grad_sum = acc[40:0];
    res.bad_position = 1'b0;
    return res;
  endfunction

  // Queue one item and update the shadow state in sending order.
  task automatic send_item(icig_pkg::req_item_t it);
    int a;
    pending_items.push_back(it);
    case (it.req_type)
      icig_pkg::REQ_COEF: begin
        if (it.tap_row < 5 && it.tap_col < 5) begin
          a = coef_index(it.set_index, it.tap_row, it.tap_col, it.in_chan, it.out_chan);
          coef_mem[a] = it.value;
          coef_written[a] = 1'b1;
        end
      end
      icig_pkg::REQ_GRAD: begin
        a = grid_index(it.row, it.col, it.out_chan);
        grad_mem[a] = it.value;
        sel_mem[a] = it.set_index;
        grad_written[a] = 1'b1;
      end
      icig_pkg::REQ_QUERY:
        expected_sums.push_back(input_gradient(it.row, it.col, it.in_chan));
      default: ;
    endcase
  endtask

  function automatic icig_pkg::req_item_t random_item(logic [1:0] kind);
    icig_pkg::req_item_t it;
    it.req_type = kind;
    it.row = 5'($urandom_range(0, 31));
    it.col = 5'($urandom_range(0, 31));
    it.out_chan = 4'($urandom_range(0, 15));
    it.in_chan = 4'($urandom_range(0, 15));
    it.tap_row = 3'($urandom_range(0, 4));
    it.tap_col = 3'($urandom_range(0, 4));
    it.set_index = 3'($urandom_range(0, 7));
    it.value = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  // Fill any never-written entry the query would read, then send the query.
  task automatic send_query(int row, int col, int ic);
    icig_pkg::req_item_t it;
    int ir, icl, ich, orw, ocl, och, kr, kc, offr, offc, gr, gc, ga, ca;
    // The item fields carry only the low bits of each coordinate.
    row = row & 31;
    col = col & 31;
    ic = ic & 15;
    ir = eff_size(icig_pkg::CFG_IN_ROWS); icl = eff_size(icig_pkg::CFG_IN_COLS);
    ich = eff_size(icig_pkg::CFG_IN_CHANNELS);
    orw = eff_size(icig_pkg::CFG_OUT_ROWS); ocl = eff_size(icig_pkg::CFG_OUT_COLS);
    och = eff_size(icig_pkg::CFG_OUT_CHANNELS);
    kr = eff_size(icig_pkg::CFG_TAP_ROWS); kc = eff_size(icig_pkg::CFG_TAP_COLS);
    if (row < ir && col < icl && ic < ich) begin
      offr = ir - 1 + kr - orw;
      offc = icl - 1 + kc - ocl;
      offr = (offr > 0) ? offr / 2 : 0;
      offc = (offc > 0) ? offc / 2 : 0;
      for (int fr = 0; fr < kr; fr++) begin
        gr = row + fr - offr;
        if (gr < 0 || gr >= orw) continue;
        for (int fc = 0; fc < kc; fc++) begin
          gc = col + fc - offc;
          if (gc < 0 || gc >= ocl) continue;
          for (int o = 0; o < och; o++) begin
            ga = grid_index(gr, gc, o);
            if (!grad_written[ga]) begin
              it = random_item(icig_pkg::REQ_GRAD);
              it.row = 5'(gr); it.col = 5'(gc); it.out_chan = 4'(o);
              send_item(it);
            end
            ca = coef_index(sel_mem[ga], kr - 1 - fr, kc - 1 - fc, ic, o);
            if (!coef_written[ca]) begin
              it = random_item(icig_pkg::REQ_COEF);
              it.set_index = sel_mem[ga]; it.tap_row = 3'(kr - 1 - fr);
              it.tap_col = 3'(kc - 1 - fc); it.in_chan = 4'(ic); it.out_chan = 4'(o);
              send_item(it);
            end
          end
        end
      end
    end
    it = random_item(icig_pkg::REQ_QUERY);
    it.row = 5'(row); it.col = 5'(col); it.in_chan = 4'(ic);
    send_item(it);
  endtask

  // Random mix of writes, queries and ignored requests.
  task automatic random_traffic(int count);
    icig_pkg::req_item_t it;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_item(random_item(icig_pkg::REQ_COEF));
      end else if (pick < 50) begin
        send_item(random_item(icig_pkg::REQ_GRAD));
      end else if (pick < 93) begin
        if ($urandom_range(0, 3) == 0)
          send_query($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 15));
        else
          send_query($urandom_range(0, eff_size(icig_pkg::CFG_IN_ROWS)),
                     $urandom_range(0, eff_size(icig_pkg::CFG_IN_COLS)),
                     $urandom_range(0, eff_size(icig_pkg::CFG_IN_CHANNELS)));
      end else if (pick < 96) begin
        // Unknown request code: dropped by the block.
        it = random_item(icig_pkg::REQ_QUERY);
        it.req_type = icig_pkg::REQ_UNUSED;
        send_item(it);
      end else begin
        // Coefficient write with a tap beyond the maximum filter size.
        it = random_item(icig_pkg::REQ_COEF);
        it.tap_row = 3'($urandom_range(0, 7));
        it.tap_col = 3'($urandom_range(5, 7));
        send_item(it);
      end
    end
  endtask

  // Let everything in flight finish, then give writes time to settle.
  task automatic drain();
    while (pending_items.size() != 0 || req_ch.valid || expected_sums.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_sizes(int v0, int v1, int v2, int v3, int v4, int v5, int v6, int v7);
    int vals [8];
    vals = '{v0, v1, v2, v3, v4, v5, v6, v7};
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= icig_pkg::CFG_IDX_W'(i);
      cfg_data <= icig_pkg::CFG_W'(vals[i]);
      size_reg[i] = vals[i] & ((i == 2 || i == 5) ? 31 : (i >= 6) ? 7 : 63);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus: reset, directed cases, then random phases over several settings.
  initial begin
    icig_pkg::req_item_t it;
    size_reg = '{32, 32, 16, 32, 32, 16, 3, 3};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A few queries at the reset sizes.
    send_query(0, 0, 0);
    send_query(31, 31, 15);
    send_query(16, 7, 9);
    drain();

    // Directed: extreme values, corners, bad positions, ignored requests.
    write_sizes(4, 4, 2, 4, 4, 2, 3, 3);
    for (int o = 0; o < 2; o++)
      for (int tr = 0; tr < 3; tr++)
        for (int tc = 0; tc < 3; tc++) begin
          it = random_item(icig_pkg::REQ_COEF);
          it.set_index = 3'd7; it.tap_row = 3'(tr); it.tap_col = 3'(tc);
          it.in_chan = 4'd0; it.out_chan = 4'(o);
          it.value = 16'sh8000;
          send_item(it);
        end
    for (int r = 0; r < 2; r++) begin
      it = random_item(icig_pkg::REQ_GRAD);
      it.row = 5'(r); it.col = 5'd0; it.out_chan = 4'd0; it.set_index = 3'd7;
      it.value = (r == 0) ? 16'sh8000 : 16'sh7fff;
      send_item(it);
    end
    send_query(0, 0, 0);
    send_query(3, 3, 1);
    send_query(4, 0, 0);
    send_query(0, 4, 0);
    send_query(0, 0, 2);
    send_query(31, 31, 15);
    it = random_item(icig_pkg::REQ_QUERY);
    it.req_type = icig_pkg::REQ_UNUSED;
    send_item(it);
    it = random_item(icig_pkg::REQ_COEF);
    it.tap_row = 3'd7; it.tap_col = 3'd5;
    send_item(it);
    send_query(1, 0, 0);
    drain();

    random_traffic(150);
    drain();
    write_sizes(1, 1, 1, 1, 1, 1, 1, 1);
    random_traffic(120);
    drain();
    write_sizes(6, 5, 3, 4, 7, 2, 5, 2);
    random_traffic(150);
    drain();
    write_sizes(0, 3, 2, 0, 3, 2, 2, 2);
    random_traffic(60);
    drain();
    write_sizes(8, 8, 4, 8, 8, 0, 0, 3);
    random_traffic(100);
    drain();
    // Full-size filters touch hundreds of entries per query, so only corners are asked.
    write_sizes(63, 63, 31, 63, 63, 31, 7, 7);
    send_query(0, 0, $urandom_range(0, 15));
    drain();
    write_sizes(32, 32, 16, 32, 32, 16, 5, 5);
    send_query(31, 31, $urandom_range(0, 15));
    drain();
    write_sizes(5, 6, 2, 3, 3, 2, 4, 5);
    random_traffic(150);
    drain();
    write_sizes(10, 3, 4, 12, 2, 3, 1, 5);
    random_traffic(150);
    drain();

    if (errors == 0)
      $display("indexed_conv_input_gradient_tb: clean");
    else
      $display("indexed_conv_input_gradient_tb: errors");
    $finish;
  end

  // Request driver: bursts of random length with random gaps.
  logic req_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
    end else if (!req_ch.valid || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        req_ch.data <= pending_items.pop_front();
        req_ch.valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall pattern changes at random intervals.
  int stall_mode = 0;
  int stall_phase = 0;

  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_phase = $urandom_range(50, 600);
      end
      stall_phase--;
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        2: rsp_ch.ready <= (stall_phase % 7) < 2;
        default: rsp_ch.ready <= (stall_phase % 23) == 0;
      endcase
    end
  end

  // Handshake monitor, result check and timeout.
  always @(posedge clk) begin
    icig_pkg::grad_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_sums.size());
      $display("indexed_conv_input_gradient_tb: errors");
      $finish;
    end
    req_taken <= !rst && req_ch.valid && req_ch.ready;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_sums.size() == 0) begin
        errors++;
        $display("%0t: unexpected result grad_sum=%0d bad_position=%0b", $time,
                 rsp_ch.data.grad_sum, rsp_ch.data.bad_position);
      end else begin
        want = expected_sums.pop_front();
        if (rsp_ch.data.grad_sum !== want.grad_sum) begin
          errors++;
          $display("%0t: grad_sum expected %0d actual %0d", $time, want.grad_sum,
                   rsp_ch.data.grad_sum);
        end
        if (rsp_ch.data.bad_position !== want.bad_position) begin
          errors++;
          $display("%0t: bad_position expected %0b actual %0b", $time, want.bad_position,
                   rsp_ch.data.bad_position);
        end
      end
    end
  end

endmodule
